### src/rfft_pkg.sv
package rfft_pkg;

  localparam int POINTS_DEFAULT      = 512;
  localparam int SAMPLE_BITS_DEFAULT = 18;
  localparam int WORD_BITS           = 28;
  localparam int TW_BITS             = 19;
  localparam int INDEX_BITS          = 9;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [63:0] PI_Q32  = 64'd13493037705;
  localparam logic [63:0] ONE_Q32 = 64'd1 << 32;

  localparam logic [63:0] COS_DIV [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };
  localparam logic [63:0] SIN_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef struct packed {
    logic                         is_read;
    logic signed [WORD_BITS-1:0]  even;
    logic signed [WORD_BITS-1:0]  odd;
    logic [INDEX_BITS-1:0]        idx;
  } req_t;

  // q1.17 cos and sin of 2*pi*k/points on the first octant, taylor series in q32
  function automatic logic [2*TW_BITS-1:0] tw_octant(input int unsigned k,
                                                     input int unsigned lgp);
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] tc;
    logic [63:0] ts;
    logic [63:0] sc;
    logic [63:0] ss;
    logic [63:0] c;
    logic [63:0] s;
    th = (64'(k) * 64'd2 * PI_Q32 + (64'd1 << (lgp - 1))) >> lgp;
    x2 = (th * th) >> 32;
    tc = ONE_Q32;
    ts = th;
    sc = ONE_Q32;
    ss = th;
    for (int n = 1; n <= 10; n++) begin
      tc = ((tc * x2) >> 32) / COS_DIV[n-1];
      ts = ((ts * x2) >> 32) / SIN_DIV[n-1];
      if (n[0]) begin
        sc = sc - tc;
        ss = ss - ts;
      end else begin
        sc = sc + tc;
        ss = ss + ts;
      end
    end
    c = (sc + (64'd1 << 14)) >> 15;
    s = (ss + (64'd1 << 14)) >> 15;
    return {c[TW_BITS-1:0], s[TW_BITS-1:0]};
  endfunction

  function automatic logic [2*TW_BITS-1:0] tw_quadrant(input int unsigned k,
                                                       input int unsigned lgp);
    int unsigned q;
    logic [2*TW_BITS-1:0] cs;
    q = (32'd1 << lgp) >> 2;
    if (k <= (q >> 1)) begin
      cs = tw_octant(k, lgp);
    end else begin
      cs = tw_octant(q - k, lgp);
      cs = {cs[TW_BITS-1:0], cs[2*TW_BITS-1:TW_BITS]};
    end
    return cs;
  endfunction

  // twiddle entry k of the half-size table, {cos, sin}
  function automatic logic [2*TW_BITS-1:0] tw_entry(input int unsigned k,
                                                    input int unsigned lgp);
    int unsigned q;
    logic [2*TW_BITS-1:0] cs;
    logic signed [TW_BITS-1:0] c;
    logic signed [TW_BITS-1:0] s;
    q = (32'd1 << lgp) >> 2;
    if (k <= q) begin
      cs = tw_quadrant(k, lgp);
    end else begin
      cs = tw_quadrant(k - q, lgp);
      c  = cs[2*TW_BITS-1:TW_BITS];
      s  = cs[TW_BITS-1:0];
      cs = {-s, c};
    end
    return cs;
  endfunction

endpackage

### src/rfft_ram.sv
module rfft_ram #(
  parameter int WIDTH = 2 * rfft_pkg::WORD_BITS,
  parameter int DEPTH = rfft_pkg::POINTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/rfft_front.sv
module rfft_front #(
  parameter int SAMPLE_BITS = rfft_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 req_type,
  input  logic signed [SAMPLE_BITS-1:0]        even_sample,
  input  logic signed [SAMPLE_BITS-1:0]        odd_sample,
  input  logic [rfft_pkg::INDEX_BITS-1:0]      read_index,
  output logic                                 q_valid,
  output rfft_pkg::req_t                       q_item,
  input  logic                                 q_pop
);
  import rfft_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          entry [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push;
  req_t          item;

  assign in_stall = (count == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = entry[rptr];

  always_comb begin
    item.is_read = req_type;
    item.even    = WORD_BITS'(even_sample);
    item.odd     = WORD_BITS'(odd_sample);
    item.idx     = read_index;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (q_pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !q_pop) begin
        count <= count + CW'(1);
      end else if (!push && q_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### src/rfft_back.sv
module rfft_back #(
  parameter int POINTS = rfft_pkg::POINTS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  rfft_pkg::req_t                       q_item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rfft_pkg::INDEX_BITS-1:0]      bin_number,
  output logic signed [rfft_pkg::WORD_BITS-1:0] bin_real,
  output logic signed [rfft_pkg::WORD_BITS-1:0] bin_imag,
  output logic                                 spectrum_ready
);
  import rfft_pkg::*;

  localparam int LGP   = $clog2(POINTS);
  localparam int LGH   = LGP - 1;
  localparam int HALF  = POINTS / 2;
  localparam int QUART = POINTS / 4;
  localparam int STW   = $clog2(LGH + 1);
  localparam int DW    = 2 * WORD_BITS;
  localparam int PRW   = WORD_BITS + TW_BITS;
  localparam int SUMW  = PRW + 1;
  localparam int TRW   = SUMW - 17;
  localparam int ACW   = TRW + 1;

  localparam logic [LGP-1:0] H_ADDR  = LGP'(HALF);
  localparam logic [LGP-1:0] Q_ADDR  = LGP'(QUART);
  localparam logic [LGP-1:0] Q3_ADDR = LGP'(3 * QUART);

  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RDD  = 4'd1;
  localparam logic [3:0] ST_RA   = 4'd2;
  localparam logic [3:0] ST_RB   = 4'd3;
  localparam logic [3:0] ST_CAP  = 4'd4;
  localparam logic [3:0] ST_RND  = 4'd5;
  localparam logic [3:0] ST_ADD  = 4'd6;
  localparam logic [3:0] ST_SPL  = 4'd7;
  localparam logic [3:0] ST_W0   = 4'd8;
  localparam logic [3:0] ST_W1   = 4'd9;
  localparam logic [3:0] ST_W2   = 4'd10;
  localparam logic [3:0] ST_W3   = 4'd11;

  localparam logic [1:0] PH_FFT   = 2'd0;
  localparam logic [1:0] PH_SPLIT = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  typedef logic [2*TW_BITS-1:0] tw_rom_t [HALF];

  function automatic tw_rom_t build_tw_rom();
    tw_rom_t rom;
    for (int k = 0; k < HALF; k++) begin
      rom[k] = tw_entry(k, LGP);
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw_rom();

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [ACW-1:0] v);
    if (v > ACW'(W_MAX)) begin
      return W_MAX;
    end else if (v < ACW'(W_MIN)) begin
      return W_MIN;
    end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [WORD_BITS-1:0] neg_sat(input logic signed [WORD_BITS-1:0] v);
    return (v == W_MIN) ? W_MAX : -v;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] halve(input logic signed [WORD_BITS:0] v);
    logic signed [WORD_BITS+1:0] w;
    w = (WORD_BITS+2)'(v) + (WORD_BITS+2)'(1);
    return sat_word(ACW'(w >>> 1));
  endfunction

  logic [3:0]      state;
  logic [1:0]      phase;
  logic [STW-1:0]  stage;
  logic [LGH-1:0]  t;
  logic [LGH-1:0]  load_count;
  logic            frame_done;

  logic [LGH-1:0]  rev;
  logic [LGH-1:0]  mask;
  logic [LGH-1:0]  fm;
  logic [LGH-1:0]  fi;
  logic [LGH-1:0]  fb;
  logic [LGH-1:0]  tw_idx;
  logic [LGP-1:0]  t_ext;
  logic [LGP-1:0]  addr_a;
  logic [LGP-1:0]  addr_b;
  logic [LGP-1:0]  addr_k;
  logic [LGP-1:0]  addr_l;
  logic [LGP-1:0]  rd_idx;
  logic            op_last;
  logic            out_free;

  logic            ram_we;
  logic [LGP-1:0]  ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic [LGP-1:0]  ram_raddr;
  logic [DW-1:0]   ram_rdata;

  logic signed [TW_BITS-1:0]   tw_c;
  logic signed [TW_BITS-1:0]   tw_s;
  logic [DW-1:0]               da;
  logic [DW-1:0]               db;
  logic signed [PRW-1:0]       p_rc;
  logic signed [PRW-1:0]       p_is;
  logic signed [PRW-1:0]       p_ic;
  logic signed [PRW-1:0]       p_rs;
  logic signed [TRW-1:0]       tr;
  logic signed [TRW-1:0]       ti;
  logic [DW-1:0]               wd0;
  logic [DW-1:0]               wd1;
  logic [DW-1:0]               wd2;
  logic [DW-1:0]               wd3;

  logic signed [WORD_BITS-1:0] re_a;
  logic signed [WORD_BITS-1:0] im_a;
  logic signed [WORD_BITS-1:0] re_b;
  logic signed [WORD_BITS-1:0] im_b;
  logic signed [WORD_BITS-1:0] rd_re;
  logic signed [WORD_BITS-1:0] rd_im;
  logic signed [SUMW-1:0]      sum_r;
  logic signed [SUMW-1:0]      sum_i;
  logic signed [WORD_BITS-1:0] re_i;
  logic signed [WORD_BITS-1:0] im_i;
  logic signed [WORD_BITS-1:0] re_k;
  logic signed [WORD_BITS-1:0] im_k;

  rfft_ram #(
    .WIDTH(DW),
    .DEPTH(POINTS)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign re_a  = da[DW-1:WORD_BITS];
  assign im_a  = da[WORD_BITS-1:0];
  assign re_b  = db[DW-1:WORD_BITS];
  assign im_b  = db[WORD_BITS-1:0];
  assign rd_re = ram_rdata[DW-1:WORD_BITS];
  assign rd_im = ram_rdata[WORD_BITS-1:0];

  assign rd_idx   = LGP'(q_item.idx);
  assign out_free = !out_valid || !out_stall;
  assign t_ext    = {1'b0, t};

  always_comb begin
    for (int b = 0; b < LGH; b++) begin
      rev[b] = load_count[LGH-1-b];
    end
  end

  // operand addresses and twiddle of the current op in each phase
  always_comb begin
    mask   = ~({LGH{1'b1}} << stage);
    fm     = t & mask;
    fi     = ((t & ~mask) << 1) | fm;
    fb     = fi | (LGH'(1) << stage);
    addr_k = H_ADDR + t_ext;
    addr_l = (t == '0) ? Q3_ADDR : LGP'(0) - t_ext;
    unique case (phase)
      PH_FFT: begin
        addr_a = {1'b0, fi};
        addr_b = {1'b0, fb};
        tw_idx = fm << (STW'(LGH) - stage);
      end
      PH_SPLIT: begin
        addr_a = t_ext;
        addr_b = (t == '0) ? Q_ADDR : H_ADDR - t_ext;
        tw_idx = '0;
      end
      default: begin
        addr_a = t_ext;
        addr_b = H_ADDR + t_ext;
        tw_idx = t;
      end
    endcase
  end

  always_comb begin
    unique case (phase)
      PH_FFT:   op_last = (t == LGH'(HALF / 2 - 1));
      PH_SPLIT: op_last = (t == LGH'(QUART - 1));
      default:  op_last = (t == LGH'(HALF - 1));
    endcase
  end

  assign q_pop = (state == ST_IDLE) && q_valid && (!q_item.is_read || out_free);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_a;
    ram_wdata = wd0;
    ram_raddr = addr_a;
    unique case (state)
      ST_IDLE: begin
        ram_we    = q_pop && !q_item.is_read;
        ram_waddr = {1'b0, rev};
        ram_wdata = {q_item.even, q_item.odd};
        ram_raddr = rd_idx;
      end
      ST_RB: begin
        ram_raddr = addr_b;
      end
      ST_W0: begin
        ram_we = 1'b1;
      end
      ST_W1: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = wd1;
      end
      ST_W2: begin
        ram_we    = 1'b1;
        ram_waddr = addr_k;
        ram_wdata = wd2;
      end
      ST_W3: begin
        ram_we    = 1'b1;
        ram_waddr = addr_l;
        ram_wdata = wd3;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // rounded twiddle products and the even/odd split
  always_comb begin
    sum_r = SUMW'(p_rc) + SUMW'(p_is) + (SUMW'(1) <<< 16);
    sum_i = SUMW'(p_ic) - SUMW'(p_rs) + (SUMW'(1) <<< 16);
    re_k  = halve((WORD_BITS+1)'(im_a) + (WORD_BITS+1)'(im_b));
    im_k  = halve((WORD_BITS+1)'(re_b) - (WORD_BITS+1)'(re_a));
    re_i  = halve((WORD_BITS+1)'(re_a) + (WORD_BITS+1)'(re_b));
    im_i  = halve((WORD_BITS+1)'(im_a) - (WORD_BITS+1)'(im_b));
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_RA: begin
        tw_c <= TW_ROM[tw_idx][2*TW_BITS-1:TW_BITS];
        tw_s <= TW_ROM[tw_idx][TW_BITS-1:0];
      end
      ST_RB: begin
        da <= ram_rdata;
      end
      ST_CAP: begin
        db   <= ram_rdata;
        p_rc <= rd_re * tw_c;
        p_is <= rd_im * tw_s;
        p_ic <= rd_im * tw_c;
        p_rs <= rd_re * tw_s;
      end
      ST_RND: begin
        tr <= TRW'(sum_r >>> 17);
        ti <= TRW'(sum_i >>> 17);
      end
      ST_ADD: begin
        wd0 <= {sat_word(ACW'(re_a) + ACW'(tr)), sat_word(ACW'(im_a) + ACW'(ti))};
        wd1 <= {sat_word(ACW'(re_a) - ACW'(tr)), sat_word(ACW'(im_a) - ACW'(ti))};
      end
      ST_SPL: begin
        if (t == '0) begin
          wd0 <= {re_a, {WORD_BITS{1'b0}}};
          wd1 <= {re_b, {WORD_BITS{1'b0}}};
          wd2 <= {im_a, {WORD_BITS{1'b0}}};
          wd3 <= {im_b, {WORD_BITS{1'b0}}};
        end else begin
          wd0 <= {re_i, im_i};
          wd1 <= {re_i, neg_sat(im_i)};
          wd2 <= {re_k, im_k};
          wd3 <= {re_k, neg_sat(im_k)};
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_IDLE && q_pop && q_item.is_read && !frame_done) ||
                 state == ST_RDD) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_pop && q_item.is_read) begin
      bin_number     <= INDEX_BITS'(rd_idx);
      bin_real       <= '0;
      bin_imag       <= '0;
      spectrum_ready <= 1'b0;
    end else if (state == ST_RDD) begin
      bin_real       <= rd_re;
      bin_imag       <= rd_im;
      spectrum_ready <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_FFT;
      stage      <= '0;
      t          <= '0;
      load_count <= '0;
      frame_done <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_item.is_read) begin
            if (frame_done) begin
              state <= ST_RDD;
            end
          end else if (q_pop) begin
            if (load_count == '0) begin
              frame_done <= 1'b0;
            end
            if (load_count == LGH'(HALF - 1)) begin
              load_count <= '0;
              phase      <= PH_FFT;
              stage      <= '0;
              t          <= '0;
              state      <= ST_RA;
            end else begin
              load_count <= load_count + LGH'(1);
            end
          end
        end
        ST_RDD: state <= ST_IDLE;
        ST_RA:  state <= ST_RB;
        ST_RB:  state <= ST_CAP;
        ST_CAP: state <= (phase == PH_SPLIT) ? ST_SPL : ST_RND;
        ST_RND: state <= ST_ADD;
        ST_ADD: state <= ST_W0;
        ST_SPL: state <= ST_W0;
        ST_W0:  state <= ST_W1;
        ST_W2:  state <= ST_W3;
        ST_W1, ST_W3: begin
          if (state == ST_W1 && phase == PH_SPLIT) begin
            state <= ST_W2;
          end else if (!op_last) begin
            t     <= t + LGH'(1);
            state <= ST_RA;
          end else begin
            t <= '0;
            unique case (phase)
              PH_FFT: begin
                state <= ST_RA;
                if (stage == STW'(LGH - 1)) begin
                  phase <= PH_SPLIT;
                end else begin
                  stage <= stage + STW'(1);
                end
              end
              PH_SPLIT: begin
                state <= ST_RA;
                phase <= PH_FINAL;
              end
              default: begin
                state      <= ST_IDLE;
                frame_done <= 1'b1;
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/real_fft_packed_half_size_core.sv
// real fft of POINTS samples through a POINTS/2-point complex fft
// request channel: in_valid/in_stall with req_type, even_sample, odd_sample,
// read_index. a load (req_type 0) carries one even/odd sample pair; after
// POINTS/2 loads the stored frame is transformed in place. a read (req_type 1)
// returns one bin on the result channel out_valid/out_stall with bin_number,
// bin_real, bin_imag and spectrum_ready; before a finished frame, or after the
// first load of a new frame, a read gives zeros with spectrum_ready low.
// requests pass through a four-entry queue, so in_stall rises only when it is
// full. a load is written to the buffer as it leaves the queue; a read's result
// passes through the queue and the result register before a finished frame, and
// also through the buffer read in state ST_RDD with one. the transform runs on
// one butterfly unit over a buffer with one write port and one read port; while
// it runs, queued requests wait.
// reset empties the queue, clears the load count and the finished-frame flag
// and drops out_valid.
// while out_stall is high with a result pending, the result register holds and reads wait in the queue.
module real_fft_packed_half_size_core #(
  parameter int POINTS      = rfft_pkg::POINTS_DEFAULT,
  parameter int SAMPLE_BITS = rfft_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic signed [SAMPLE_BITS-1:0]         even_sample,
  input  logic signed [SAMPLE_BITS-1:0]         odd_sample,
  input  logic [rfft_pkg::INDEX_BITS-1:0]       read_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rfft_pkg::INDEX_BITS-1:0]       bin_number,
  output logic signed [rfft_pkg::WORD_BITS-1:0] bin_real,
  output logic signed [rfft_pkg::WORD_BITS-1:0] bin_imag,
  output logic                                  spectrum_ready
);
  import rfft_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_item;

  rfft_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .even_sample(even_sample),
    .odd_sample (odd_sample),
    .read_index (read_index),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  rfft_back #(
    .POINTS(POINTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bin_number    (bin_number),
    .bin_real      (bin_real),
    .bin_imag      (bin_imag),
    .spectrum_ready(spectrum_ready)
  );

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rfft_pkg::*;

  localparam int NPTS = 512;
  localparam int NHALF = NPTS / 2;
  localparam int LIMIT = 600000;
  localparam bit REQ_LOAD = 1'b0;
  localparam bit REQ_READ = 1'b1;
  localparam longint WMAX = 134217727;
  localparam longint WMIN = -134217728;
  localparam logic [63:0] PI_FIX = 64'd13493037705;

  typedef struct {
    bit kind;
    logic signed [17:0] ev;
    logic signed [17:0] od;
    logic [8:0] idx;
  } request_t;

  typedef struct {
    logic [8:0] idx;
    logic signed [27:0] re;
    logic signed [27:0] im;
    logic rdy;
  } bin_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic signed [17:0] even_sample = '0;
  logic signed [17:0] odd_sample = '0;
  logic [8:0] read_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [8:0] bin_number;
  logic signed [27:0] bin_real;
  logic signed [27:0] bin_imag;
  logic spectrum_ready;

  request_t pending_reqs[$];
  bin_t expected_bins[$];
  longint spec_re[NPTS];
  longint spec_im[NPTS];
  longint tw_cos[NHALF];
  longint tw_sin[NHALF];
  int pairs_loaded = 0;
  bit spectrum_held = 0;
  bit req_taken = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int cycles = 0;
  int bins_checked = 0;
  int frames_done = 0;

  real_fft_packed_half_size_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .even_sample(even_sample), .odd_sample(odd_sample),
    .read_index(read_index), .out_valid(out_valid), .out_stall(out_stall),
    .bin_number(bin_number), .bin_real(bin_real), .bin_imag(bin_imag),
    .spectrum_ready(spectrum_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip28(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint rnd17(longint v);
    return (v + 65536) >>> 17;
  endfunction

  function automatic longint half_rnd(longint v);
    return (v + 1) >>> 1;
  endfunction

  // first-octant cos/sin in q17 from a q32 taylor series
  task automatic octant_cs(input int unsigned k, output longint c, output longint s);
    logic [63:0] th, x2, tc, ts, sc, ss;
    th = (64'd2 * 64'(k) * PI_FIX + 64'(NPTS / 2)) / 64'(NPTS);
    x2 = (th * th) >> 32;
    tc = 64'd1 << 32;
    ts = th;
    sc = tc;
    ss = th;
    for (int n = 1; n <= 10; n++) begin
      tc = ((tc * x2) >> 32) / 64'((2 * n - 1) * (2 * n));
      ts = ((ts * x2) >> 32) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sc = sc - tc;
        ss = ss - ts;
      end else begin
        sc = sc + tc;
        ss = ss + ts;
      end
    end
    c = longint'((sc + 64'd16384) >> 15);
    s = longint'((ss + 64'd16384) >> 15);
  endtask

  task automatic quadrant_cs(input int unsigned k, output longint c, output longint s);
    if (k <= NPTS / 8) octant_cs(k, c, s);
    else octant_cs(NPTS / 4 - k, s, c);
  endtask

  task automatic build_twiddles();
    longint c, s;
    for (int k = 0; k < NHALF; k++) begin
      if (k <= NPTS / 4) begin
        quadrant_cs(k, c, s);
        tw_cos[k] = c;
        tw_sin[k] = s;
      end else begin
        quadrant_cs(k - NPTS / 4, c, s);
        tw_cos[k] = -s;
        tw_sin[k] = c;
      end
    end
  endtask

  task automatic bfly(input int a, input int b, input longint c, input longint s);
    longint tr, ti;
    tr = rnd17(spec_re[b] * c + spec_im[b] * s);
    ti = rnd17(spec_im[b] * c - spec_re[b] * s);
    spec_re[b] = clip28(spec_re[a] - tr);
    spec_im[b] = clip28(spec_im[a] - ti);
    spec_re[a] = clip28(spec_re[a] + tr);
    spec_im[a] = clip28(spec_im[a] + ti);
  endtask

  task automatic run_transform();
    int r, j, k, l, half_len;
    longint t;
    for (int i = 0; i < NHALF; i++) begin
      r = 0;
      for (int b = 0; b < 8; b++)
        if (i[b]) r |= 1 << (7 - b);
      if (i < r) begin
        t = spec_re[i]; spec_re[i] = spec_re[r]; spec_re[r] = t;
        t = spec_im[i]; spec_im[i] = spec_im[r]; spec_im[r] = t;
      end
    end
    for (int len = 2; len <= NHALF; len = len * 2) begin
      half_len = len / 2;
      for (int m = 0; m < half_len; m++)
        for (int i = m; i < NHALF; i += len)
          bfly(i, i + half_len, tw_cos[m * (NPTS / len)], tw_sin[m * (NPTS / len)]);
    end
    for (int i = 1; i < NPTS / 4; i++) begin
      k = i + NHALF;
      j = NHALF - i;
      l = j + NHALF;
      spec_re[k] = clip28(half_rnd(spec_im[i] + spec_im[j]));
      spec_re[l] = spec_re[k];
      spec_im[k] = clip28(half_rnd(spec_re[j] - spec_re[i]));
      spec_im[l] = clip28(-spec_im[k]);
      spec_re[i] = clip28(half_rnd(spec_re[i] + spec_re[j]));
      spec_re[j] = spec_re[i];
      spec_im[i] = clip28(half_rnd(spec_im[i] - spec_im[j]));
      spec_im[j] = clip28(-spec_im[i]);
    end
    spec_re[NPTS - NPTS / 4] = spec_im[NPTS / 4];
    spec_re[NHALF] = spec_im[0];
    spec_im[NPTS - NPTS / 4] = 0;
    spec_im[NHALF] = 0;
    spec_im[NPTS / 4] = 0;
    spec_im[0] = 0;
    for (int i = 0; i < NHALF; i++)
      bfly(i, i + NHALF, tw_cos[i], tw_sin[i]);
  endtask

  task automatic predict_request();
    bin_t b;
    int idx;
    if (req_type == REQ_LOAD) begin
      if (pairs_loaded == 0) spectrum_held = 0;
      spec_re[pairs_loaded] = longint'(even_sample);
      spec_im[pairs_loaded] = longint'(odd_sample);
      pairs_loaded++;
      if (pairs_loaded == NHALF) begin
        run_transform();
        pairs_loaded = 0;
        spectrum_held = 1;
        frames_done++;
      end
    end else begin
      idx = read_index;
      b.idx = read_index;
      b.rdy = spectrum_held;
      b.re = spectrum_held ? spec_re[idx][27:0] : '0;
      b.im = spectrum_held ? spec_im[idx][27:0] : '0;
      expected_bins.push_back(b);
    end
  endtask

  // accept side: prediction and result checking
  always @(posedge clk) begin
    bin_t b;
    if (!rst) begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_request();
      if (out_valid && !out_stall) begin
        if (expected_bins.size() == 0) begin
          $display("%0t: expected no result, got bin %0d re %0d im %0d rdy %0b",
                   $time, bin_number, bin_real, bin_imag, spectrum_ready);
          errors++;
        end else begin
          b = expected_bins.pop_front();
          bins_checked++;
          if (bin_number !== b.idx || bin_real !== b.re || bin_imag !== b.im ||
              spectrum_ready !== b.rdy) begin
            $display("%0t: mismatch exp bin %0d re %0d im %0d rdy %0b, got bin %0d re %0d im %0d rdy %0b",
                     $time, b.idx, b.re, b.im, b.rdy,
                     bin_number, bin_real, bin_imag, spectrum_ready);
            errors++;
          end
        end
      end
    end
  end

  // request driver and random out_stall
  always @(negedge clk) begin
    request_t r;
    if (!rst) begin
      out_stall <= ($urandom_range(99) < recv_idle);
      if (!in_valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= r.kind;
          even_sample <= r.ev;
          odd_sample <= r.od;
          read_index <= r.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[real_fft_packed_half_size_core] ERROR");
      $finish;
    end
  end

  task automatic push_req(bit kind, logic signed [17:0] ev, logic signed [17:0] od,
                          logic [8:0] idx);
    request_t r;
    r.kind = kind;
    r.ev = ev;
    r.od = od;
    r.idx = idx;
    pending_reqs.push_back(r);
  endtask

  function automatic logic signed [17:0] pick_sample(int mode);
    case (mode)
      0: return 18'($urandom);
      1: return $urandom_range(1) ? 18'sh1ffff : 18'sh20000;
      2: return 18'($signed($urandom_range(32)) - 16);
      default: return 18'sd100000;
    endcase
  endfunction

  // one frame of loads with reads mixed in, then reads of the finished spectrum
  task automatic queue_frame(int mode);
    for (int i = 0; i < NHALF; i++) begin
      if ($urandom_range(15) == 0) push_req(REQ_READ, 18'($urandom), 18'($urandom), 9'($urandom));
      push_req(REQ_LOAD, pick_sample(mode), pick_sample(mode), 9'($urandom));
    end
    push_req(REQ_READ, '0, '0, 9'd0);
    push_req(REQ_READ, '0, '0, 9'd128);
    push_req(REQ_READ, '0, '0, 9'd256);
    push_req(REQ_READ, '0, '0, 9'd384);
    push_req(REQ_READ, '1, '1, 9'd511);
    for (int i = 0; i < 5; i++) push_req(REQ_READ, 18'($urandom), 18'($urandom), 9'($urandom));
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() != 0 || in_valid || expected_bins.size() != 0);
  endtask

  initial begin
    build_twiddles();
    for (int i = 0; i < NPTS; i++) begin
      spec_re[i] = 0;
      spec_im[i] = 0;
    end
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    // reads before any frame, then extremes
    push_req(REQ_READ, '0, '0, 9'd0);
    push_req(REQ_READ, '1, '1, 9'd511);
    push_req(REQ_READ, '0, '0, 9'd256);
    push_req(REQ_READ, '0, '0, 9'd1);
    send_idle = 25;
    recv_idle = 63;
    queue_frame(1);
    queue_frame(0);
    drain();
    send_idle = 63;
    recv_idle = 25;
    queue_frame(2);
    queue_frame(3);
    drain();
    send_idle = 0;
    recv_idle = 0;
    queue_frame(0);
    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d transformed frames and %0d checked bin reads", frames_done,
             bins_checked);
    $display("frames: full-scale extremes, random, small, constant and random again");
    if (errors == 0) begin
      $display("[real_fft_packed_half_size_core] OK");
    end else begin
      $display("[real_fft_packed_half_size_core] ERROR");
    end
    $finish;
  end

endmodule
